>>> hw/rtl/bmf_pkg.sv
// bmf_pkg: shared constants for the box mean filter
// no dependencies
`default_nettype none
package bmf_pkg;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF = 1'b1;
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;
  localparam int SIDE_RESET = 1024;
  localparam int HALF_RESET = 1;
endpackage
`default_nettype wire

>>> hw/rtl/bmf_ram.sv
// bmf_ram: generic single write, single read ram with registered read
// no dependencies
`default_nettype none
module bmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/bmf_front.sv
// bmf_front: config registers, raster tracking, line store writes, job queue
// depends on bmf_pkg
`default_nettype none
module bmf_front import bmf_pkg::*; #(
  parameter int MAX_SIDE   = 1024,
  parameter int MAX_HALF   = 7,
  parameter int PIXEL_BITS = 16,
  parameter int SIDE_W     = 11,
  parameter int HALF_W     = 3,
  parameter int COORD_W    = 10,
  parameter int POS_W      = 21,
  parameter int ADDR_W     = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic                  in_kind,
  input  wire logic [PIXEL_BITS-1:0] in_pixel,
  output      logic                  wr_en,
  output      logic [ADDR_W-1:0]     wr_addr,
  output      logic [PIXEL_BITS-1:0] wr_data,
  output      logic [SIDE_W-1:0]     side,
  output      logic [HALF_W-1:0]     half,
  output      logic                  job_valid,
  input  wire logic                  job_ready,
  output      logic [COORD_W-1:0]    job_ky,
  output      logic [COORD_W-1:0]    job_kx,
  output      logic                  job_last,
  input  wire logic                  back_busy
);
  localparam int JOB_W = 2 * COORD_W + 1;

  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   frame;
  logic [POS_W-1:0]   lag;
  logic [COORD_W-1:0] kx;
  logic [COORD_W-1:0] ky;
  logic               hold;
  logic [JOB_W-1:0]   q [2];
  logic               wptr;
  logic               rptr;
  logic [1:0]         count;
  logic               fire;
  logic               emit;
  logic               last;
  logic               pop;
  logic [CFG_DATA_W-1:0] side_cfg;
  logic [2:0]            half_cfg;

  assign fire     = in_valid && in_ready;
  assign in_ready = !hold && (count != 2'd2);
  assign frame    = POS_W'(side) * POS_W'(side);
  assign lag      = POS_W'(half) * POS_W'(side) + POS_W'(half);
  assign emit     = pos >= lag;
  assign last     = (SIDE_W'(kx) == side - SIDE_W'(1)) && (SIDE_W'(ky) == side - SIDE_W'(1));
  assign pop      = job_valid && job_ready;
  assign wr_en    = fire && (pos < frame);
  assign wr_addr  = pos[ADDR_W-1:0];
  assign wr_data  = (in_kind == KIND_DRAIN) ? '0 : in_pixel;
  assign job_valid = count != 2'd0;
  assign {job_ky, job_kx, job_last} = q[rptr];

  always_comb begin
    side_cfg = cfg_data;
    if (side_cfg == '0) begin
      side_cfg = CFG_DATA_W'(1);
    end else if (32'(side_cfg) > MAX_SIDE) begin
      side_cfg = CFG_DATA_W'(MAX_SIDE);
    end
    half_cfg = cfg_data[2:0];
    if (32'(half_cfg) > MAX_HALF) begin
      half_cfg = 3'(MAX_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      q[wptr] <= {ky, kx, last};
    end
    if (rst) begin
      side  <= SIDE_W'((MAX_SIDE < SIDE_RESET) ? MAX_SIDE : SIDE_RESET);
      half  <= HALF_W'((MAX_HALF < HALF_RESET) ? MAX_HALF : HALF_RESET);
      pos   <= '0;
      kx    <= '0;
      ky    <= '0;
      hold  <= 1'b0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (pop) begin
        rptr <= !rptr;
      end
      if (fire && emit) begin
        wptr <= !wptr;
      end
      count <= count + 2'((fire && emit) ? 1 : 0) - 2'(pop ? 1 : 0);
      if (!back_busy && count == 2'd0) begin
        hold <= 1'b0;
      end
      if (cfg_we) begin
        pos <= '0;
        kx  <= '0;
        ky  <= '0;
        unique case (cfg_index)
          CFG_SIDE: side <= SIDE_W'(side_cfg);
          CFG_HALF: half <= HALF_W'(half_cfg);
          default: ;
        endcase
      end else if (fire) begin
        if (emit && last) begin
          pos  <= '0;
          kx   <= '0;
          ky   <= '0;
          hold <= 1'b1;
        end else begin
          pos <= pos + POS_W'(1);
          if (emit) begin
            if (SIDE_W'(kx) == side - SIDE_W'(1)) begin
              kx <= '0;
              ky <= ky + COORD_W'(1);
            end else begin
              kx <= kx + COORD_W'(1);
            end
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/bmf_back.sv
// bmf_back: window scan over the line store, serial divide, output register
// depends on bmf_pkg
`default_nettype none
module bmf_back import bmf_pkg::*; #(
  parameter int MAX_HALF   = 7,
  parameter int PIXEL_BITS = 16,
  parameter int SIDE_W     = 11,
  parameter int HALF_W     = 3,
  parameter int COORD_W    = 10,
  parameter int POS_W      = 21,
  parameter int ADDR_W     = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [SIDE_W-1:0]     side,
  input  wire logic [HALF_W-1:0]     half,
  input  wire logic                  job_valid,
  output      logic                  job_ready,
  input  wire logic [COORD_W-1:0]    job_ky,
  input  wire logic [COORD_W-1:0]    job_kx,
  input  wire logic                  job_last,
  output      logic                  busy,
  output      logic [ADDR_W-1:0]     rd_addr,
  input  wire logic [PIXEL_BITS-1:0] rd_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [PIXEL_BITS-1:0] out_data,
  output      logic                  out_last
);
  localparam int CELLS  = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int SUM_W  = PIXEL_BITS + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int CW     = COORD_W + HALF_W + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state;
  logic [COORD_W-1:0]  ky;
  logic [COORD_W-1:0]  kx;
  logic                last;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] dx;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    cells;
  logic [CNT_W:0]      rem;
  logic [STEP_W-1:0]   step;
  logic                pend;
  logic signed [CW-1:0] yy;
  logic signed [CW-1:0] xx;
  logic signed [CW-1:0] hs;
  logic signed [CW-1:0] ss;
  logic                in_img;
  logic [POS_W-1:0]    lin;
  logic [CNT_W+1:0]    rem_sh;
  logic                fits;

  assign hs = $signed(CW'(half));
  assign ss = $signed(CW'(side));
  assign yy = $signed(CW'(ky)) + dy;
  assign xx = $signed(CW'(kx)) + dx;
  assign in_img = (yy >= 0) && (xx >= 0) && (yy < ss) && (xx < ss);
  assign lin = POS_W'(yy[COORD_W-1:0]) * POS_W'(side) + POS_W'(xx[COORD_W-1:0]);
  assign rd_addr = lin[ADDR_W-1:0];
  assign job_ready = state == S_IDLE;
  assign busy = state != S_IDLE;
  assign rem_sh = {rem, sum[SUM_W-1]};
  assign fits = rem_sh >= (CNT_W + 2)'(cells);

  always_ff @(posedge clk) begin
    if (pend) begin
      sum <= sum + SUM_W'(rd_data);
    end
    unique case (state)
      S_IDLE: begin
        ky    <= job_ky;
        kx    <= job_kx;
        last  <= job_last;
        dy    <= -hs;
        dx    <= -hs;
        sum   <= '0;
        cells <= '0;
      end
      S_SCAN: begin
        if (in_img) begin
          cells <= cells + CNT_W'(1);
        end
        if (dx == hs) begin
          dx <= -hs;
          dy <= dy + CW'(1);
        end else begin
          dx <= dx + CW'(1);
        end
      end
      S_FLUSH: begin
        rem  <= '0;
        step <= '0;
      end
      S_DIV: begin
        rem  <= fits ? (CNT_W + 1)'(rem_sh - (CNT_W + 2)'(cells)) : rem_sh[CNT_W:0];
        sum  <= {sum[SUM_W-2:0], fits};
        step <= step + STEP_W'(1);
      end
      S_DONE: ;
      default: ;
    endcase
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data <= sum[PIXEL_BITS-1:0];
      out_last <= last;
    end
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= (state == S_SCAN) && in_img;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:  if (job_valid) state <= S_SCAN;
        S_SCAN:  if (dx == hs && dy == hs) state <= S_FLUSH;
        S_FLUSH: state <= S_DIV;
        S_DIV:   if (step == STEP_W'(SUM_W - 1)) state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/box_mean_filter_clipped_edges.sv
// box_mean_filter_clipped_edges: top level, front, back and line store ram
// depends on bmf_pkg, bmf_ram, bmf_front, bmf_back
// an item that gives no result only writes the line store; an item that gives
// a result queues a job whose time is set by the one-read-per-cycle window
// scan of the line store and the bit-serial divider
// sync reset clears control; the line store is not cleared and needs no sweep
`default_nettype none
module box_mean_filter_clipped_edges import bmf_pkg::*; #(
  parameter int MAX_SIDE   = 1024,
  parameter int MAX_HALF   = 7,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [((PIXEL_BITS+7)/8)*8-1:0] in_tdata,  // pixel
  input  wire logic                  in_tuser,  // kind
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [((PIXEL_BITS+7)/8)*8-1:0] out_tdata,  // smoothed
  output      logic                  out_tlast
);
  localparam int TD_W    = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1) + 1;
  localparam int HALF_W  = (MAX_HALF > 0) ? $clog2(MAX_HALF + 1) : 1;
  localparam int COORD_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int DEPTH_REQ = (2 * MAX_HALF + 1) * MAX_SIDE;
  localparam int ADDR_W  = (DEPTH_REQ > 1) ? $clog2(DEPTH_REQ) : 1;
  localparam int POS_RAW = $clog2(MAX_SIDE * MAX_SIDE + 1) + 1;
  localparam int POS_W   = (POS_RAW > ADDR_W) ? POS_RAW : ADDR_W;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [PIXEL_BITS-1:0] wr_data;
  logic [ADDR_W-1:0]     rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;
  logic [SIDE_W-1:0]     side;
  logic [HALF_W-1:0]     half;
  logic                  job_valid;
  logic                  job_ready;
  logic [COORD_W-1:0]    job_ky;
  logic [COORD_W-1:0]    job_kx;
  logic                  job_last;
  logic                  back_busy;
  logic [PIXEL_BITS-1:0] smoothed;

  assign out_tdata = TD_W'(smoothed);

  bmf_front #(
    .MAX_SIDE(MAX_SIDE), .MAX_HALF(MAX_HALF), .PIXEL_BITS(PIXEL_BITS),
    .SIDE_W(SIDE_W), .HALF_W(HALF_W), .COORD_W(COORD_W),
    .POS_W(POS_W), .ADDR_W(ADDR_W)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_kind(in_tuser), .in_pixel(in_tdata[PIXEL_BITS-1:0]),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .side(side), .half(half),
    .job_valid(job_valid), .job_ready(job_ready),
    .job_ky(job_ky), .job_kx(job_kx), .job_last(job_last),
    .back_busy(back_busy)
  );

  bmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(1 << ADDR_W)) u_store (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rd_data)
  );

  bmf_back #(
    .MAX_HALF(MAX_HALF), .PIXEL_BITS(PIXEL_BITS),
    .SIDE_W(SIDE_W), .HALF_W(HALF_W), .COORD_W(COORD_W),
    .POS_W(POS_W), .ADDR_W(ADDR_W)
  ) u_back (
    .clk(clk), .rst(rst),
    .side(side), .half(half),
    .job_valid(job_valid), .job_ready(job_ready),
    .job_ky(job_ky), .job_kx(job_kx), .job_last(job_last),
    .busy(back_busy),
    .rd_addr(rd_addr), .rd_data(rd_data),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_data(smoothed), .out_last(out_tlast)
  );
endmodule
`default_nettype wire
